FILE: rtl/uartrf_pkg.sv
// ----------------------------------------------------------------------------
// uartrf_pkg
// Shared types, offsets and constants of the UART register file with
// receive ring.
// ----------------------------------------------------------------------------
package uartrf_pkg;

    // ring geometry
    localparam int RX_DEPTH  = 4096;
    localparam int RX_IDX_W  = $clog2(RX_DEPTH);
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;

    // reset value of the window base
    localparam logic [WORD_W-1:0] WINDOW_BASE_RESET = 32'h0900_0000;

    // register offsets
    localparam logic [WORD_W-1:0] OFF_DR    = 32'h0000_0000;
    localparam logic [WORD_W-1:0] OFF_RSR   = 32'h0000_0004;
    localparam logic [WORD_W-1:0] OFF_FR    = 32'h0000_0018;
    localparam logic [WORD_W-1:0] OFF_ILPR  = 32'h0000_0020;
    localparam logic [WORD_W-1:0] OFF_IBRD  = 32'h0000_0024;
    localparam logic [WORD_W-1:0] OFF_FBRD  = 32'h0000_0028;
    localparam logic [WORD_W-1:0] OFF_LCRH  = 32'h0000_002c;
    localparam logic [WORD_W-1:0] OFF_CR    = 32'h0000_0030;
    localparam logic [WORD_W-1:0] OFF_IFLS  = 32'h0000_0034;
    localparam logic [WORD_W-1:0] OFF_IMSC  = 32'h0000_0038;
    localparam logic [WORD_W-1:0] OFF_RIS   = 32'h0000_003c;
    localparam logic [WORD_W-1:0] OFF_MIS   = 32'h0000_0040;
    localparam logic [WORD_W-1:0] OFF_ICR   = 32'h0000_0044;
    localparam logic [WORD_W-1:0] OFF_DMACR = 32'h0000_0048;

    // identification words
    localparam logic [WORD_W-1:0] OFF_PID0  = 32'h0000_0fe0;
    localparam logic [WORD_W-1:0] OFF_PID1  = 32'h0000_0fe4;
    localparam logic [WORD_W-1:0] OFF_PID2  = 32'h0000_0fe8;
    localparam logic [WORD_W-1:0] OFF_PID3  = 32'h0000_0fec;
    localparam logic [WORD_W-1:0] OFF_CID0  = 32'h0000_0ff0;
    localparam logic [WORD_W-1:0] OFF_CID1  = 32'h0000_0ff4;
    localparam logic [WORD_W-1:0] OFF_CID2  = 32'h0000_0ff8;
    localparam logic [WORD_W-1:0] OFF_CID3  = 32'h0000_0ffc;

    localparam logic [WORD_W-1:0] PID0_VAL  = 32'h0000_0011;
    localparam logic [WORD_W-1:0] PID1_VAL  = 32'h0000_0010;
    localparam logic [WORD_W-1:0] PID2_VAL  = 32'h0000_0014;
    localparam logic [WORD_W-1:0] PID3_VAL  = 32'h0000_0000;
    localparam logic [WORD_W-1:0] CID0_VAL  = 32'h0000_000d;
    localparam logic [WORD_W-1:0] CID1_VAL  = 32'h0000_00f0;
    localparam logic [WORD_W-1:0] CID2_VAL  = 32'h0000_0005;
    localparam logic [WORD_W-1:0] CID3_VAL  = 32'h0000_00b1;

    // flag and interrupt bits
    localparam logic [WORD_W-1:0] FLAG_TXFE = 32'h0000_0080;
    localparam logic [WORD_W-1:0] FLAG_RXFE = 32'h0000_0010;
    localparam logic [WORD_W-1:0] INT_RX    = 32'h0000_0010;

    // operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } op_e;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_WINDOW_BASE = 1'b0,
        CFG_IRQ_ENABLED = 1'b1
    } cfg_reg_e;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_e;

    typedef struct packed {
        op_e                operation;
        logic [WORD_W-1:0]  address;
        logic [WORD_W-1:0]  write_data;
        logic [BYTE_W-1:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               handled;
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               irq_line;
        logic               rx_dropped;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;
    } dp_status_t;

    // ring index advance with wrap
    function automatic logic [RX_IDX_W-1:0] next_idx(input logic [RX_IDX_W-1:0] idx);
        logic [RX_IDX_W-1:0] res;
        if (idx == RX_IDX_W'(RX_DEPTH - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

endpackage

FILE: rtl/uartrf_ram.sv
// ----------------------------------------------------------------------------
// uartrf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module uartrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/uartrf_ctrl.sv
// ----------------------------------------------------------------------------
// uartrf_ctrl
// Controller: accepts one transaction, then executes and commits it once
// the result register is free.
// ----------------------------------------------------------------------------
module uartrf_ctrl import uartrf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_e state_reg;
    ctrl_state_e state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!status.out_blocked)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !status.out_blocked;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // a loaded transaction is executed next
    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("load did not move to execute");

    // a committed transaction frees the controller
    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE && in_ready))
        else $error("commit did not return to idle");

endmodule

FILE: rtl/uartrf_datapath.sv
// ----------------------------------------------------------------------------
// uartrf_datapath
// Datapath: configuration, register words, ring indices, ring memory,
// offset decode and the result register.
// ----------------------------------------------------------------------------
module uartrf_datapath import uartrf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    input  cfg_reg_e   cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    logic [WORD_W-1:0]   window_base_reg;
    logic                irq_enabled_reg;

    logic [RX_IDX_W-1:0] rd_idx_reg,  rd_idx_next;
    logic [RX_IDX_W-1:0] wr_idx_reg,  wr_idx_next;
    logic [WORD_W-1:0]   baud_int_reg,  baud_int_next;
    logic [WORD_W-1:0]   baud_frac_reg, baud_frac_next;
    logic [WORD_W-1:0]   lcrh_reg,  lcrh_next;
    logic [WORD_W-1:0]   cr_reg,    cr_next;
    logic [WORD_W-1:0]   ifls_reg,  ifls_next;
    logic [WORD_W-1:0]   imsc_reg,  imsc_next;
    logic [WORD_W-1:0]   dmacr_reg, dmacr_next;

    in_item_t            item_reg;
    out_item_t           out_item_reg;
    out_item_t           res;
    logic                out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]   offset;
    logic                has_data;
    logic                has_data_after;
    logic [WORD_W-1:0]   raw_now;
    logic [WORD_W-1:0]   raw_after;
    logic [RX_IDX_W-1:0] rd_inc;
    logic [RX_IDX_W-1:0] wr_inc;
    logic                ring_full;
    logic                ring_we;
    logic [BYTE_W-1:0]   ring_rdata;

    // receive ring storage, read address follows the read index
    uartrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wr_idx_reg),
        .wdata (item_reg.rx_byte),
        .raddr (rd_idx_reg),
        .rdata (ring_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= WINDOW_BASE_RESET;
            irq_enabled_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_BASE: window_base_reg <= cfg_data;
                CFG_IRQ_ENABLED: irq_enabled_reg <= cfg_data[0];
                default:         irq_enabled_reg <= irq_enabled_reg;
            endcase
        end
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // ring and decode helpers
    assign offset    = item_reg.address - window_base_reg;
    assign has_data  = (rd_idx_reg != wr_idx_reg);
    assign raw_now   = has_data ? INT_RX : '0;
    assign rd_inc    = next_idx(rd_idx_reg);
    assign wr_inc    = next_idx(wr_idx_reg);
    assign ring_full = (wr_inc == rd_idx_reg);

    // execute one transaction
    always_comb
    begin
        res            = '0;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        baud_int_next  = baud_int_reg;
        baud_frac_next = baud_frac_reg;
        lcrh_next      = lcrh_reg;
        cr_next        = cr_reg;
        ifls_next      = ifls_reg;
        imsc_next      = imsc_reg;
        dmacr_next     = dmacr_reg;
        ring_we        = 1'b0;

        unique case (item_reg.operation)
            OP_READ:
            begin
                res.handled = 1'b1;
                unique case (offset)
                    OFF_PID0:  res.read_data = PID0_VAL;
                    OFF_PID1:  res.read_data = PID1_VAL;
                    OFF_PID2:  res.read_data = PID2_VAL;
                    OFF_PID3:  res.read_data = PID3_VAL;
                    OFF_CID0:  res.read_data = CID0_VAL;
                    OFF_CID1:  res.read_data = CID1_VAL;
                    OFF_CID2:  res.read_data = CID2_VAL;
                    OFF_CID3:  res.read_data = CID3_VAL;
                    OFF_DR:
                    begin
                        // pop the ring, empty ring reads zero
                        if (has_data)
                        begin
                            res.read_data = {{(WORD_W-BYTE_W){1'b0}}, ring_rdata};
                            rd_idx_next   = rd_inc;
                        end
                    end
                    OFF_RSR:   res.read_data = '0;
                    OFF_ILPR:  res.read_data = '0;
                    OFF_FR:    res.read_data = FLAG_TXFE | (has_data ? '0 : FLAG_RXFE);
                    OFF_IBRD:  res.read_data = baud_int_reg;
                    OFF_FBRD:  res.read_data = baud_frac_reg;
                    OFF_LCRH:  res.read_data = lcrh_reg;
                    OFF_CR:    res.read_data = cr_reg;
                    OFF_IFLS:  res.read_data = ifls_reg;
                    OFF_IMSC:  res.read_data = imsc_reg;
                    OFF_RIS:   res.read_data = raw_now;
                    OFF_MIS:   res.read_data = raw_now & imsc_reg;
                    OFF_DMACR: res.read_data = dmacr_reg;
                    default:   res.handled   = 1'b0;
                endcase
            end
            OP_WRITE:
            begin
                res.handled = 1'b1;
                unique case (offset)
                    OFF_DR:
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = item_reg.write_data[BYTE_W-1:0];
                    end
                    OFF_RSR:   res.handled    = 1'b1;
                    OFF_ILPR:  res.handled    = 1'b1;
                    OFF_ICR:   res.handled    = 1'b1;
                    OFF_IBRD:  baud_int_next  = item_reg.write_data;
                    OFF_FBRD:  baud_frac_next = item_reg.write_data;
                    OFF_LCRH:  lcrh_next      = item_reg.write_data;
                    OFF_CR:    cr_next        = item_reg.write_data;
                    OFF_IFLS:  ifls_next      = item_reg.write_data;
                    OFF_IMSC:  imsc_next      = item_reg.write_data;
                    OFF_DMACR: dmacr_next     = item_reg.write_data;
                    default:   res.handled    = 1'b0;
                endcase
            end
            OP_RX:
            begin
                // push unless the ring is full
                if (ring_full)
                begin
                    res.rx_dropped = 1'b1;
                end
                else
                begin
                    ring_we     = cmd.commit;
                    wr_idx_next = wr_inc;
                end
            end
            OP_NONE:
            begin
                res.handled = 1'b0;
            end
            default:
            begin
                res.handled = 1'b0;
            end
        endcase

        // interrupt line after this transaction
        has_data_after = (rd_idx_next != wr_idx_next);
        raw_after      = has_data_after ? INT_RX : '0;
        res.irq_line   = irq_enabled_reg && ((raw_after & imsc_next) != '0);
    end

    // architectural state, updated on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            baud_int_reg  <= '0;
            baud_frac_reg <= '0;
            lcrh_reg      <= '0;
            cr_reg        <= '0;
            ifls_reg      <= '0;
            imsc_reg      <= '0;
            dmacr_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            baud_int_reg  <= baud_int_next;
            baud_frac_reg <= baud_frac_next;
            lcrh_reg      <= lcrh_next;
            cr_reg        <= cr_next;
            ifls_reg      <= ifls_next;
            imsc_reg      <= imsc_next;
            dmacr_reg     <= dmacr_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_item           = out_item_reg;
    assign status.out_blocked = out_valid_reg && !out_ready;

    // a dropped byte leaves the write index alone
    a_drop_keeps_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && item_reg.operation == OP_RX && ring_full) |=> $stable(wr_idx_reg))
        else $error("write index moved on a dropped byte");

    // an empty ring is never popped
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !has_data) |=> $stable(rd_idx_reg))
        else $error("read index moved on an empty ring");

    // a transmitted byte always comes from a handled write
    a_tx_handled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.tx_valid) |-> out_item_reg.handled)
        else $error("transmit byte without handled write");

endmodule

FILE: rtl/uart_register_file_with_rx_ring.sv
// a transaction is captured in the item register when accepted, then commits into the
//   result register in the execute state once that is free; no new one is accepted before
//   that commit, and the execute state covers the registered read of the ring memory
// a waiting result holds the execute state only until the result register is taken
// reset: control, ring indices and register words clear at once, no clearing pass;
//   ring contents stay undefined until written
// ----------------------------------------------------------------------------
// uart_register_file_with_rx_ring
// UART register subset with receive ring: bus reads and writes, received
// bytes, transmit byte and interrupt level per transaction.
// ----------------------------------------------------------------------------
module uart_register_file_with_rx_ring import uartrf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_reg_e          cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration writes always taken
    assign cfg_ready = 1'b1;

    // controller
    uartrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    uartrf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: bench/uartrf_checker.sv
// ----------------------------------------------------------------------------
// uartrf_checker
// Watches the bus/rx, response and configuration channels of the UART
// register file, keeps a shadow of its registers and receive ring, and
// compares every response transaction against the predicted one.
// ----------------------------------------------------------------------------
module uartrf_checker import uartrf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_item_t          in_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_item_t         out_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  cfg_reg_e          cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    output int                fail_count,
    output int                outstanding,
    output int                responses_checked,
    output int                overflows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // shadow configuration
    logic [WORD_W-1:0]   win_base;
    logic                irq_on;

    // shadow receive ring and register words
    logic [BYTE_W-1:0]   rx_shadow [RX_DEPTH];
    logic [RX_IDX_W-1:0] rd_ptr;
    logic [RX_IDX_W-1:0] wr_ptr;
    logic [WORD_W-1:0]   baud_int;
    logic [WORD_W-1:0]   baud_frac;
    logic [WORD_W-1:0]   lcrh_word;
    logic [WORD_W-1:0]   cr_word;
    logic [WORD_W-1:0]   ifls_word;
    logic [WORD_W-1:0]   imsc_word;
    logic [WORD_W-1:0]   dmacr_word;

    // predicted responses, oldest first
    out_item_t           pending_responses [$];
    int                  errs;
    int                  checked;
    int                  drops;

    function automatic logic [RX_IDX_W-1:0] ring_step(input logic [RX_IDX_W-1:0] ptr);
        return (ptr == RX_IDX_W'(RX_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // applies one transaction to the shadow state and returns its response
    function automatic out_item_t compute_uart_response(input in_item_t item);
        out_item_t           resp;
        logic [WORD_W-1:0]   off;
        logic [RX_IDX_W-1:0] nxt;
        logic [WORD_W-1:0]   rx_pending;
        resp = '0;
        off  = item.address - win_base;
        case (item.operation)
            OP_READ:
            begin
                resp.handled = 1'b1;
                case (off)
                    OFF_PID0:  resp.read_data = PID0_VAL;
                    OFF_PID1:  resp.read_data = PID1_VAL;
                    OFF_PID2:  resp.read_data = PID2_VAL;
                    OFF_PID3:  resp.read_data = PID3_VAL;
                    OFF_CID0:  resp.read_data = CID0_VAL;
                    OFF_CID1:  resp.read_data = CID1_VAL;
                    OFF_CID2:  resp.read_data = CID2_VAL;
                    OFF_CID3:  resp.read_data = CID3_VAL;
                    OFF_DR:
                    begin
                        // pop when data waits, else zero
                        if (rd_ptr != wr_ptr)
                        begin
                            resp.read_data = {{(WORD_W-BYTE_W){1'b0}}, rx_shadow[rd_ptr]};
                            rd_ptr = ring_step(rd_ptr);
                        end
                    end
                    OFF_RSR, OFF_ILPR: resp.read_data = '0;
                    OFF_FR:    resp.read_data = FLAG_TXFE | ((rd_ptr != wr_ptr) ? '0 : FLAG_RXFE);
                    OFF_IBRD:  resp.read_data = baud_int;
                    OFF_FBRD:  resp.read_data = baud_frac;
                    OFF_LCRH:  resp.read_data = lcrh_word;
                    OFF_CR:    resp.read_data = cr_word;
                    OFF_IFLS:  resp.read_data = ifls_word;
                    OFF_IMSC:  resp.read_data = imsc_word;
                    OFF_RIS:   resp.read_data = (rd_ptr != wr_ptr) ? INT_RX : '0;
                    OFF_MIS:   resp.read_data = ((rd_ptr != wr_ptr) ? INT_RX : '0) & imsc_word;
                    OFF_DMACR: resp.read_data = dmacr_word;
                    default:   resp.handled = 1'b0;
                endcase
            end
            OP_WRITE:
            begin
                resp.handled = 1'b1;
                case (off)
                    OFF_DR:
                    begin
                        resp.tx_valid = 1'b1;
                        resp.tx_byte  = item.write_data[BYTE_W-1:0];
                    end
                    OFF_RSR, OFF_ILPR, OFF_ICR: ;
                    OFF_IBRD:  baud_int   = item.write_data;
                    OFF_FBRD:  baud_frac  = item.write_data;
                    OFF_LCRH:  lcrh_word  = item.write_data;
                    OFF_CR:    cr_word    = item.write_data;
                    OFF_IFLS:  ifls_word  = item.write_data;
                    OFF_IMSC:  imsc_word  = item.write_data;
                    OFF_DMACR: dmacr_word = item.write_data;
                    default:   resp.handled = 1'b0;
                endcase
            end
            OP_RX:
            begin
                // ring keeps one slot free, a byte into a full ring is lost
                nxt = ring_step(wr_ptr);
                if (nxt == rd_ptr)
                    resp.rx_dropped = 1'b1;
                else
                begin
                    rx_shadow[wr_ptr] = item.rx_byte;
                    wr_ptr = nxt;
                end
            end
            default: ;
        endcase
        // interrupt line after the update
        rx_pending    = (rd_ptr != wr_ptr) ? INT_RX : '0;
        resp.irq_line = irq_on && ((rx_pending & imsc_word) != '0);
        return resp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp;
        if (!rst_n)
        begin
            win_base   = WINDOW_BASE_RESET;
            irq_on     = 1'b0;
            rd_ptr     = '0;
            wr_ptr     = '0;
            baud_int   = '0;
            baud_frac  = '0;
            lcrh_word  = '0;
            cr_word    = '0;
            ifls_word  = '0;
            imsc_word  = '0;
            dmacr_word = '0;
            pending_responses.delete();
            errs    = 0;
            checked = 0;
            drops   = 0;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WINDOW_BASE: win_base = cfg_data;
                    CFG_IRQ_ENABLED: irq_on   = cfg_data[0];
                    default: ;
                endcase
            end

            // response transaction, always older than one accepted at this edge
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    errs++;
                    if (errs <= REPORT_LIMIT)
                        $display("%0t: response with no transaction pending: rd=%h h=%b",
                                 $realtime, out_item.read_data, out_item.handled);
                end
                else
                begin
                    exp = pending_responses.pop_front();
                    checked++;
                    if (out_item.read_data  !== exp.read_data  ||
                        out_item.handled    !== exp.handled    ||
                        out_item.tx_valid   !== exp.tx_valid   ||
                        out_item.tx_byte    !== exp.tx_byte    ||
                        out_item.irq_line   !== exp.irq_line   ||
                        out_item.rx_dropped !== exp.rx_dropped)
                    begin
                        errs++;
                        if (errs <= REPORT_LIMIT)
                        begin
                            $display("%0t: response %0d mismatch", $realtime, checked);
                            $display("  exp rd=%h h=%b tx=%b/%h irq=%b drop=%b",
                                     exp.read_data, exp.handled, exp.tx_valid, exp.tx_byte,
                                     exp.irq_line, exp.rx_dropped);
                            $display("  got rd=%h h=%b tx=%b/%h irq=%b drop=%b",
                                     out_item.read_data, out_item.handled, out_item.tx_valid,
                                     out_item.tx_byte, out_item.irq_line, out_item.rx_dropped);
                        end
                    end
                end
            end

            // bus or rx transaction
            if (in_valid && in_ready)
            begin
                exp = compute_uart_response(in_item);
                if (exp.rx_dropped)
                    drops++;
                pending_responses.push_back(exp);
            end
        end
        outstanding       <= pending_responses.size();
        fail_count        <= errs;
        responses_checked <= checked;
        overflows_seen    <= drops;
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UART register file with receive ring: a
// directed pass over registers and corners, a partial ring fill and
// drain, then random bus and rx traffic under several window bases,
// interrupt settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uartrf_pkg::*;

    localparam int CYCLE_LIMIT      = 400_000;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int RANDOM_PHASES    = 8;
    localparam int RING_FILL        = 8;

    // offsets with no register behind them
    localparam logic [WORD_W-1:0] OFF_HOLE      = 32'h0000_0008;
    localparam logic [WORD_W-1:0] OFF_PAST_MAP  = 32'h0000_004c;
    localparam logic [WORD_W-1:0] OFF_PAST_IDS  = 32'h0000_1000;
    localparam logic [WORD_W-1:0] OFF_UNALIGNED = 32'h0000_0002;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // idle patterns of the two sides
    typedef enum logic [1:0] {
        FLOW_STEADY,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_e;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_item;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_reg_e          cfg_index;
    logic [WORD_W-1:0] cfg_data;

    flow_e             flow;
    logic [WORD_W-1:0] cur_base;
    logic [WORD_W-1:0] offset_pool [26];
    int                sent_count;
    int                cycle_count;
    int                fail_count;
    int                outstanding;
    int                responses_checked;
    int                overflows_seen;

    uart_register_file_with_rx_ring dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uartrf_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_item           (in_item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_item          (out_item),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .overflows_seen    (overflows_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d responses still pending",
                     cycle_count, outstanding);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // response side backpressure
    always @(posedge clk)
    begin
        case (flow)
            FLOW_SINK_STALLS: out_ready <= ($urandom_range(0, 99) >= 65);
            FLOW_BOTH:        out_ready <= ($urandom_range(0, 99) >= 15);
            default:          out_ready <= 1'b1;
        endcase
    end

    // present one transaction, with random gaps ahead of it
    task automatic send_transaction(input in_item_t item);
        int gap_pct;
        gap_pct = (flow == FLOW_SRC_GAPS) ? 65 : (flow == FLOW_BOTH) ? 15 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drive_op(input op_e op, input logic [WORD_W-1:0] off,
                            input logic [WORD_W-1:0] data, input logic [BYTE_W-1:0] rx);
        in_item_t item;
        item.operation  = op;
        item.address    = cur_base + off;
        item.write_data = data;
        item.rx_byte    = rx;
        send_transaction(item);
    endtask

    // mostly mapped accesses, some rx bytes, a little noise
    function automatic in_item_t make_random_item();
        in_item_t item;
        int       pick;
        pick            = $urandom_range(0, 99);
        item.write_data = $urandom();
        item.rx_byte    = BYTE_W'($urandom_range(0, 255));
        item.address    = cur_base + offset_pool[$urandom_range(0, 25)];
        if (pick < 40)
        begin
            item.operation = OP_READ;
            if ($urandom_range(0, 2) == 0)
                item.address = cur_base + OFF_DR;
        end
        else if (pick < 66)
            item.operation = OP_WRITE;
        else if (pick < 88)
            item.operation = OP_RX;
        else if (pick < 97)
        begin
            item.operation = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
            item.address   = $urandom();
        end
        else
            item.operation = OP_NONE;
        return item;
    endfunction

    // wait until every response is back and the block has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // program both registers while idle
    task automatic configure(input logic [WORD_W-1:0] base, input logic irq, input flow_e f);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_BASE;
        cfg_data  <= base;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_IRQ_ENABLED;
        cfg_data  <= {31'($urandom()), irq};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_base = base;
        flow     = f;
    endtask

    initial
    begin
        logic [WORD_W-1:0] base;
        logic              irq;
        offset_pool = '{OFF_DR, OFF_RSR, OFF_FR, OFF_ILPR, OFF_IBRD, OFF_FBRD, OFF_LCRH,
                        OFF_CR, OFF_IFLS, OFF_IMSC, OFF_RIS, OFF_MIS, OFF_ICR, OFF_DMACR,
                        OFF_PID0, OFF_PID1, OFF_PID2, OFF_PID3,
                        OFF_CID0, OFF_CID1, OFF_CID2, OFF_CID3,
                        OFF_HOLE, OFF_PAST_MAP, OFF_PAST_IDS, OFF_UNALIGNED};
        flow     = FLOW_STEADY;
        cur_base = WINDOW_BASE_RESET;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WINDOW_BASE;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, ids, status, read-only and write-only words
        drive_op(OP_READ,  OFF_DR,   '0, '0);
        configure(WINDOW_BASE_RESET, 1'b1, FLOW_STEADY);
        drive_op(OP_READ,  OFF_FR,   '0, '0);
        drive_op(OP_READ,  OFF_PID0, '0, '0);
        drive_op(OP_READ,  OFF_CID3, '0, '0);
        drive_op(OP_WRITE, OFF_IMSC, ALL_ONES, '0);
        drive_op(OP_RX,    OFF_DR,   '0, 8'hff);
        drive_op(OP_RX,    OFF_DR,   '0, 8'h00);
        drive_op(OP_READ,  OFF_RIS,  '0, '0);
        drive_op(OP_READ,  OFF_MIS,  '0, '0);
        drive_op(OP_READ,  OFF_FR,   '0, '0);
        drive_op(OP_READ,  OFF_DR,   '0, '0);
        drive_op(OP_READ,  OFF_DR,   '0, '0);
        drive_op(OP_READ,  OFF_DR,   '0, '0);
        drive_op(OP_WRITE, OFF_DR,   ALL_ONES, '0);
        drive_op(OP_WRITE, OFF_DR,   '0, '0);
        drive_op(OP_WRITE, OFF_FR,   ALL_ONES, '0);
        drive_op(OP_WRITE, OFF_PID0, ALL_ONES, '0);
        drive_op(OP_WRITE, OFF_MIS,  ALL_ONES, '0);
        drive_op(OP_READ,  OFF_ICR,  '0, '0);
        drive_op(OP_WRITE, OFF_ICR,  ALL_ONES, '0);
        drive_op(OP_WRITE, OFF_RSR,  ALL_ONES, '0);
        drive_op(OP_READ,  OFF_ILPR, '0, '0);
        drive_op(OP_WRITE, OFF_IBRD, ALL_ONES, '0);
        drive_op(OP_READ,  OFF_IBRD, '0, '0);
        drive_op(OP_WRITE, OFF_PAST_MAP, ALL_ONES, '0);
        drive_op(OP_READ,  ALL_ONES - cur_base, '0, '0);
        drive_op(OP_NONE,  ALL_ONES - cur_base, ALL_ONES, 8'hff);

        // partial ring fill, mask checks, then drain through the data register
        configure(WINDOW_BASE_RESET, 1'b1, FLOW_BOTH);
        repeat (RING_FILL)
            drive_op(OP_RX, OFF_DR, $urandom(), BYTE_W'($urandom_range(0, 255)));
        drive_op(OP_READ,  OFF_FR,   '0, '0);
        drive_op(OP_WRITE, OFF_IMSC, '0, '0);
        drive_op(OP_READ,  OFF_MIS,  '0, '0);
        drive_op(OP_WRITE, OFF_IMSC, INT_RX, '0);
        repeat (RING_FILL + 1)
            drive_op(OP_READ, OFF_DR, '0, '0);
        drive_op(OP_RX,   OFF_DR, '0, 8'h5a);
        drive_op(OP_READ, OFF_DR, '0, '0);

        // random traffic under several bases, interrupt settings and idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin base = '0;                irq = 1'b1; end
                1:       begin base = ALL_ONES;          irq = 1'b0; end
                3:       begin base = WINDOW_BASE_RESET; irq = 1'b1; end
                4:       begin base = 32'hffff_fff0;     irq = 1'b1; end
                6:       begin base = 32'h8000_0000;     irq = 1'b1; end
                7:       begin base = WINDOW_BASE_RESET; irq = 1'b0; end
                default: begin base = $urandom();        irq = p[1]; end
            endcase
            configure(base, irq, flow_e'(p % 4));
            repeat (RANDOM_PER_PHASE)
                send_transaction(make_random_item());
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("sent %0d transactions (directed, ring fill and drain, %0d random phases)",
                 sent_count, RANDOM_PHASES);
        $display("checked %0d responses, %0d overflow drops, %0d mismatches, %0d cycles",
                 responses_checked, overflows_seen, fail_count, cycle_count);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/uartrf_pkg.sv
rtl/uartrf_ram.sv
rtl/uartrf_ctrl.sv
rtl/uartrf_datapath.sv
rtl/uart_register_file_with_rx_ring.sv
bench/uartrf_checker.sv
bench/tb_top.sv
